[rtl/ksl_pkg.sv]
// Shared types and constants for the keyed slot table.
// Used by ksl_ctrl, keyed_slot_table_top and the testbench; depends on nothing.
package ksl_pkg;

    localparam int CAPACITY   = 32;
    localparam int FLOOR_BITS = 6;
    localparam int TIME_BITS  = 32;

    localparam int OCC_BITS   = 6;
    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDX_BITS   = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = FLOOR_BITS + TIME_BITS;

    localparam logic [OCC_BITS-1:0] SLOTS_RESET = OCC_BITS'(32);

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STAT_ADDED   = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REMOVED = 2'd2,
        STAT_DONE    = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        status_t               status;
        logic [TIME_BITS-1:0]  removed_time;
        logic [OCC_BITS-1:0]   occupancy;
        logic [OCC_BITS-1:0]   removed_count;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [ENTRY_BITS-1:0] wr_data;
        logic [ADDR_BITS-1:0]  rd_addr;
    } mem_req_t;

endpackage

[rtl/ksl_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module ksl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 38
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ksl_ctrl.sv]
// Scan sequencer of the keyed slot table: valid bits, occupancy, result register.
// Depends on ksl_pkg; drives the entry RAM through a mem_req_t.
module ksl_ctrl
    import ksl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_BITS-1:0]   limit,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [FLOOR_BITS-1:0] key_floor,
    input  logic [TIME_BITS-1:0]  entry_time,
    output mem_req_t              mem_req,
    input  logic [ENTRY_BITS-1:0] mem_rd_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output result_t               result
);

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    command_t              cmd_reg, cmd_next;
    logic [FLOOR_BITS-1:0] key_reg, key_next;
    logic [TIME_BITS-1:0]  time_reg, time_next;
    logic [CAPACITY-1:0]   valid_reg, valid_next;
    logic [OCC_BITS-1:0]   count_reg, count_next;
    logic [OCC_BITS-1:0]   removed_reg, removed_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               res_reg, res_next;

    logic                  out_free;
    logic                  at_end;
    logic [ADDR_BITS-1:0]  slot;
    logic [FLOOR_BITS-1:0] rd_floor;
    logic [TIME_BITS-1:0]  rd_time;

    assign slot     = idx_reg[ADDR_BITS-1:0];
    assign at_end   = (idx_reg == limit);
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_floor = mem_rd_data[ENTRY_BITS-1:TIME_BITS];
    assign rd_time  = mem_rd_data[TIME_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            removed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        time_reg <= time_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        time_next      = time_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        in_stall       = 1'b1;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = slot;
        mem_req.wr_data = {key_reg, time_reg};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next     = command_t'(command);
                    key_next     = key_floor;
                    time_next    = entry_time;
                    idx_next     = '0;
                    removed_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (at_end)
                begin
                    if (out_free)
                    begin
                        res_next.status        = (cmd_reg == CMD_ADD) ? STAT_FULL : STAT_DONE;
                        res_next.removed_time  = '0;
                        res_next.occupancy     = count_reg;
                        res_next.removed_count = (cmd_reg == CMD_ADD) ? '0 : removed_reg;
                        res_next.last          = 1'b1;
                        out_valid_next         = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end
                else if (cmd_reg == CMD_ADD)
                begin
                    if (!valid_reg[slot])
                    begin
                        if (out_free)
                        begin
                            mem_req.wr_en          = 1'b1;
                            valid_next[slot]       = 1'b1;
                            count_next             = count_reg + 1'b1;
                            res_next.status        = STAT_ADDED;
                            res_next.removed_time  = '0;
                            res_next.occupancy     = count_reg + 1'b1;
                            res_next.removed_count = '0;
                            res_next.last          = 1'b1;
                            out_valid_next         = 1'b1;
                            state_next             = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (valid_reg[slot] && (rd_floor == key_reg))
                    begin
                        if (out_free)
                        begin
                            valid_next[slot]       = 1'b0;
                            count_next             = count_reg - 1'b1;
                            removed_next           = removed_reg + 1'b1;
                            res_next.status        = STAT_REMOVED;
                            res_next.removed_time  = rd_time;
                            res_next.occupancy     = count_reg - 1'b1;
                            res_next.removed_count = '0;
                            res_next.last          = 1'b0;
                            out_valid_next         = 1'b1;
                            idx_next               = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mem_req.rd_addr = idx_next[ADDR_BITS-1:0];
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

[rtl/keyed_slot_table_top.sv]
// Top level of the keyed slot table: limit register, entry RAM and scan sequencer.
// Depends on ksl_pkg, ksl_ram and ksl_ctrl.
//
//   port group   dir  handshake             payload
//   in           in   in_valid / in_stall   command, key_floor, entry_time
//   out          out  out_valid / out_stall status, removed_time, occupancy,
//                                           removed_count, last
//   cfg          in   cfg_valid / cfg_ready cfg_data (slots_in_use)
//
// A request is accepted in idle; the scan then walks the slots up to the slot
// limit. An add ends at the first free slot, or reports full at the limit.
// The scan rate is set by the single RAM read port, one slot per cycle.
// A stalled output holds the scan on the slot that has a result to give.
// Reset clears the valid bits and occupancy; RAM contents are not cleared.
module keyed_slot_table_top
    import ksl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic [FLOOR_BITS-1:0] key_floor,
    input  logic [TIME_BITS-1:0]  entry_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [TIME_BITS-1:0]  removed_time,
    output logic [OCC_BITS-1:0]   occupancy,
    output logic [OCC_BITS-1:0]   removed_count,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OCC_BITS-1:0]   cfg_data
);

    logic [OCC_BITS-1:0]   slots_reg;
    logic [IDX_BITS-1:0]   limit;
    mem_req_t              mem_req;
    logic [ENTRY_BITS-1:0] mem_rd_data;
    result_t               result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            slots_reg <= cfg_data;
        end
    end

    assign limit = (slots_reg > OCC_BITS'(CAPACITY)) ? IDX_BITS'(CAPACITY)
                                                     : IDX_BITS'(slots_reg);

    ksl_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    ksl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key_floor   (key_floor),
        .entry_time  (entry_time),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    assign status        = result.status;
    assign removed_time  = result.removed_time;
    assign occupancy     = result.occupancy;
    assign removed_count = result.removed_count;
    assign last          = result.last;

endmodule

[test/keyed_slot_table_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for keyed_slot_table_top: directed and random add/remove requests
// checked against a behavioral mirror of the slot table, with random input gaps and stalls.
// Depends on ksl_pkg and the keyed_slot_table_top RTL.
module keyed_slot_table_top_tb;
    import ksl_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 10;

    class slot_table_mirror;
        int unsigned           limit;
        bit                    held [CAPACITY];
        logic [FLOOR_BITS-1:0] floor_key [CAPACITY];
        logic [TIME_BITS-1:0]  stamp [CAPACITY];
        logic [OCC_BITS-1:0]   occupied;
        result_t               pending_results [$];
        int                    errors;
        int                    results_seen;
        int                    entries_freed;

        function new();
            limit         = 32'(SLOTS_RESET);
            occupied      = '0;
            errors        = 0;
            results_seen  = 0;
            entries_freed = 0;
            foreach (held[i])
                held[i] = 1'b0;
        endfunction

        function void apply_request(command_t cmd, logic [FLOOR_BITS-1:0] key,
                                    logic [TIME_BITS-1:0] entry_stamp);
            int                  span;
            bit                  placed;
            logic [OCC_BITS-1:0] freed;
            result_t             r;
            span   = (limit > CAPACITY) ? CAPACITY : int'(limit);
            placed = 1'b0;
            freed  = '0;
            r.removed_time  = '0;
            r.removed_count = '0;
            if (cmd == CMD_ADD)
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (!placed && !held[i])
                    begin
                        held[i]      = 1'b1;
                        floor_key[i] = key;
                        stamp[i]     = entry_stamp;
                        occupied++;
                        placed = 1'b1;
                    end
                end
                if (placed)
                    r.status = STAT_ADDED;
                else
                    r.status = STAT_FULL;
                r.occupancy = occupied;
                r.last      = 1'b1;
                pending_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (held[i] && floor_key[i] == key)
                    begin
                        held[i] = 1'b0;
                        occupied--;
                        freed++;
                        r.status        = STAT_REMOVED;
                        r.removed_time  = stamp[i];
                        r.occupancy     = occupied;
                        r.removed_count = '0;
                        r.last          = 1'b0;
                        pending_results.push_back(r);
                    end
                end
                r.status        = STAT_DONE;
                r.removed_time  = '0;
                r.occupancy     = occupied;
                r.removed_count = freed;
                r.last          = 1'b1;
                pending_results.push_back(r);
                entries_freed += int'(freed);
            end
        endfunction

        function void check_result(logic [1:0] st, logic [TIME_BITS-1:0] rtime,
                                   logic [OCC_BITS-1:0] occ, logic [OCC_BITS-1:0] cnt,
                                   logic fin);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: status %0d", st);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (st !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, st);
                    errors++;
                end
                if (rtime !== want.removed_time)
                begin
                    $error("removed_time: expected %h, got %h", want.removed_time, rtime);
                    errors++;
                end
                if (occ !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, occ);
                    errors++;
                end
                if (cnt !== want.removed_count)
                begin
                    $error("removed_count: expected %0d, got %0d", want.removed_count, cnt);
                    errors++;
                end
                if (fin !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, fin);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [FLOOR_BITS-1:0] key_floor;
    logic [TIME_BITS-1:0]  entry_time;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            status;
    logic [TIME_BITS-1:0]  removed_time;
    logic [OCC_BITS-1:0]   occupancy;
    logic [OCC_BITS-1:0]   removed_count;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [OCC_BITS-1:0]   cfg_data;

    slot_table_mirror mirror = new();
    bit no_idle;
    int cycle_count;
    int requests_sent;
    int adds_sent;
    int removes_sent;

    keyed_slot_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .key_floor    (key_floor),
        .entry_time   (entry_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .removed_time (removed_time),
        .occupancy    (occupancy),
        .removed_count(removed_count),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles, then take one result.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            mirror.check_result(status, removed_time, occupancy, removed_count, last);
        end
    end

    task automatic send_request(command_t cmd, logic [FLOOR_BITS-1:0] key,
                                logic [TIME_BITS-1:0] entry_stamp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= cmd;
        key_floor  <= key;
        entry_time <= entry_stamp;
        do @(posedge clk); while (!(in_valid && !in_stall));
        mirror.apply_request(cmd, key, entry_stamp);
        requests_sent++;
        if (cmd == CMD_ADD)
            adds_sent++;
        else
            removes_sent++;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic hold_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [OCC_BITS-1:0] value);
        hold_until_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        mirror.limit = 32'(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                    pool [4];
        int                    phase_limit [PHASES];
        int                    phase_items;
        int                    add_pct;
        logic [FLOOR_BITS-1:0] key;
        command_t              cmd;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ADD;
        key_floor     = '0;
        entry_time    = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        no_idle       = 1'b0;
        requests_sent = 0;
        adds_sent     = 0;
        removes_sent  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit: empty remove, multi-match remove, field extremes.
        send_request(CMD_REMOVE, 6'd0, 32'h0000_0000);
        send_request(CMD_ADD, 6'd0, 32'h0000_0000);
        send_request(CMD_ADD, 6'd63, 32'hFFFF_FFFF);
        send_request(CMD_ADD, 6'd0, 32'hAAAA_AAAA);
        send_request(CMD_ADD, 6'd21, 32'h5555_5555);
        send_request(CMD_REMOVE, 6'd0, 32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 6'd63, 32'h0000_0000);

        // Lowered limit: fill, report full, leave the entry above the limit alone.
        write_limit(6'd2);
        send_request(CMD_ADD, 6'd21, 32'h0000_0001);
        send_request(CMD_ADD, 6'd21, 32'h8000_0000);
        send_request(CMD_ADD, 6'd42, 32'h1234_5678);
        send_request(CMD_REMOVE, 6'd21, 32'h0000_0000);

        write_limit(6'd0);
        send_request(CMD_ADD, 6'd21, 32'hDEAD_BEEF);
        send_request(CMD_REMOVE, 6'd21, 32'h0000_0000);

        // Limit above capacity reaches the stranded entry again.
        write_limit(6'd63);
        send_request(CMD_ADD, 6'd42, 32'hCAFE_F00D);
        send_request(CMD_REMOVE, 6'd21, 32'h0000_0000);

        phase_limit    = '{32, 1, 63, 0, 8, 0, 32, 3, 5, 32};
        phase_limit[5] = $urandom_range(0, 63);
        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(OCC_BITS'(phase_limit[p]));
            no_idle = (p % 4 == 2);
            foreach (pool[k])
                pool[k] = $urandom_range(0, 63);
            phase_items = (p == 0) ? 36 : 29;
            add_pct     = (p == 0) ? 100 : $urandom_range(35, 75);
            for (int n = 0; n < phase_items; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    hold_until_idle();
                if ($urandom_range(1, 100) <= add_pct)
                    cmd = CMD_ADD;
                else
                    cmd = CMD_REMOVE;
                if ($urandom_range(0, 4) == 0)
                    key = FLOOR_BITS'($urandom_range(0, 63));
                else
                    key = FLOOR_BITS'(pool[$urandom_range(0, 3)]);
                send_request(cmd, key, $urandom);
            end
        end

        hold_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d adds, %0d removes) across %0d slot limits, 0 to 63.",
                 requests_sent, adds_sent, removes_sent, PHASES + 4);
        $display("Checked %0d results; %0d entries freed by removes.",
                 mirror.results_seen, mirror.entries_freed);
        if (mirror.errors == 0 && mirror.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
